[hw/rtl/vpi_pkg.sv]
// Shared types, constants and helpers of the Verlet point integrator.
package vpi_pkg;

  localparam int REST_FRAMES_DEF = 10;

  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 104;
  localparam int CFG_IDX_W   = 3;

  localparam logic signed [32:0] GRAVITY_Q16 = -33'sd642908;
  localparam logic [15:0]        DRAG_RESET  = 16'd32768;
  localparam logic [31:0]        THR_RESET   = 32'd4295;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_DISPLACE = 2'd1,
    CMD_SET_REST = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL_X   = 3'd0,
    CFG_ACCEL_Y   = 3'd1,
    CFG_ACCEL_Z   = 3'd2,
    CFG_DRAG      = 3'd3,
    CFG_GRAVITY   = 3'd4,
    CFG_REST_THR  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic tick_run;
  } dp_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/vpi_lane.sv]
// One axis of the integrator: multiplier chain, saturation and squared move.
module vpi_lane
  import vpi_pkg::*;
(
  input  logic               clk,
  input  logic signed [32:0] accel,
  input  logic [15:0]        dt,
  input  logic signed [31:0] cur,
  input  logic signed [31:0] prev,
  input  logic [15:0]        drag,
  output logic signed [31:0] new_pos,
  output logic [31:0]        sq,
  output logic               big
);

  logic signed [16:0] dt_s;
  logic signed [16:0] drag_s;
  logic signed [49:0] p1;
  logic signed [32:0] q1;
  logic signed [49:0] p2;
  logic signed [32:0] t;
  logic signed [32:0] diff;
  logic signed [33:0] s_sum;
  logic signed [50:0] m;
  logic signed [35:0] m_sh;
  logic signed [36:0] pos_sum;
  logic signed [32:0] d;
  logic signed [16:0] d_lo;
  logic signed [33:0] sq_full;

  assign dt_s    = $signed({1'b0, dt});
  assign drag_s  = $signed({1'b0, drag});
  assign q1      = p1[48:16];
  assign t       = p2[48:16];
  assign s_sum   = {diff[32], diff} + {t[32], t};
  assign m_sh    = m[50:15];
  assign pos_sum = {{5{cur[31]}}, cur} + {m_sh[35], m_sh};
  assign d       = {new_pos[31], new_pos} - {cur[31], cur};
  assign d_lo    = d[16:0];
  assign sq_full = d_lo * d_lo;

  always_ff @(posedge clk) begin
    p1      <= accel * dt_s;
    diff    <= {cur[31], cur} - {prev[31], prev};
    p2      <= q1 * dt_s;
    m       <= s_sum * drag_s;
    new_pos <= sat32(pos_sum);
    sq      <= sq_full[31:0];
    big     <= (d > 33'sd65535) || (d < -33'sd65535);
  end

endmodule

[hw/rtl/vpi_datapath.sv]
// Datapath: configuration, body state, operand latch, three lanes and commit.
module vpi_datapath
  import vpi_pkg::*;
#(
  parameter int REST_FRAMES = REST_FRAMES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [1:0]             s_tuser,
  input  logic                   cfg_wr,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]            cfg_data,
  input  ctrl_cmd_t              cmd,
  output dp_status_t             status,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam logic [3:0] RestLim = 4'(REST_FRAMES);

  logic signed [31:0] accel_x, accel_y, accel_z;
  logic [15:0]        drag_factor;
  logic               gravity_on;
  logic [31:0]        rest_threshold;

  logic signed [31:0] cur_x, cur_y, cur_z, prev_x, prev_y, prev_z;
  logic signed [31:0] cur_x_next, cur_y_next, cur_z_next;
  logic signed [31:0] prev_x_next, prev_y_next, prev_z_next;
  logic [3:0]         still_count, still_count_next;
  logic               rest_flag, rest_flag_next;

  logic [1:0]         l_cmd;
  logic [15:0]        l_dt;
  logic signed [31:0] l_dx, l_dy, l_dz;
  logic               l_rv;

  logic signed [32:0] accel_y_eff;
  logic signed [31:0] new_x, new_y, new_z;
  logic [31:0]        sq_x, sq_y, sq_z;
  logic               big_x, big_y, big_z;
  logic [33:0]        sq_sum;
  logic               still;
  logic [3:0]         cnt_inc;

  assign status.tick_run = (s_tuser == CMD_TICK) && !rest_flag;

  assign accel_y_eff = {accel_y[31], accel_y} + (gravity_on ? GRAVITY_Q16 : 33'sd0);

  vpi_lane u_lane_x (
    .clk(clk), .accel({accel_x[31], accel_x}), .dt(l_dt), .cur(cur_x), .prev(prev_x),
    .drag(drag_factor), .new_pos(new_x), .sq(sq_x), .big(big_x)
  );

  vpi_lane u_lane_y (
    .clk(clk), .accel(accel_y_eff), .dt(l_dt), .cur(cur_y), .prev(prev_y),
    .drag(drag_factor), .new_pos(new_y), .sq(sq_y), .big(big_y)
  );

  vpi_lane u_lane_z (
    .clk(clk), .accel({accel_z[31], accel_z}), .dt(l_dt), .cur(cur_z), .prev(prev_z),
    .drag(drag_factor), .new_pos(new_z), .sq(sq_z), .big(big_z)
  );

  assign sq_sum  = {2'b00, sq_x} + {2'b00, sq_y} + {2'b00, sq_z};
  assign still   = !(big_x || big_y || big_z) && (sq_sum < {2'b00, rest_threshold});
  assign cnt_inc = still_count + 4'd1;

  always_comb begin
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    cur_z_next       = cur_z;
    prev_x_next      = prev_x;
    prev_y_next      = prev_y;
    prev_z_next      = prev_z;
    still_count_next = still_count;
    rest_flag_next   = rest_flag;
    case (l_cmd)
      CMD_TICK: begin
        if (!rest_flag) begin
          prev_x_next = cur_x;
          prev_y_next = cur_y;
          prev_z_next = cur_z;
          cur_x_next  = new_x;
          cur_y_next  = new_y;
          cur_z_next  = new_z;
          if (still) begin
            if (cnt_inc == RestLim) begin
              rest_flag_next   = 1'b1;
              still_count_next = 4'd0;
            end else begin
              still_count_next = cnt_inc;
            end
          end else begin
            still_count_next = 4'd0;
          end
        end
      end
      CMD_DISPLACE: begin
        cur_x_next  = sat32(37'(cur_x) + 37'(l_dx));
        cur_y_next  = sat32(37'(cur_y) + 37'(l_dy));
        cur_z_next  = sat32(37'(cur_z) + 37'(l_dz));
        prev_x_next = sat32(37'(prev_x) + 37'(l_dx));
        prev_y_next = sat32(37'(prev_y) + 37'(l_dy));
        prev_z_next = sat32(37'(prev_z) + 37'(l_dz));
      end
      CMD_SET_REST: begin
        rest_flag_next = l_rv;
        if (l_rv) begin
          still_count_next = 4'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      l_cmd <= s_tuser;
      l_dt  <= s_tdata[15:0];
      l_dx  <= s_tdata[47:16];
      l_dy  <= s_tdata[79:48];
      l_dz  <= s_tdata[111:80];
      l_rv  <= s_tdata[112];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_x        <= '0;
      accel_y        <= '0;
      accel_z        <= '0;
      drag_factor    <= DRAG_RESET;
      gravity_on     <= 1'b0;
      rest_threshold <= THR_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_ACCEL_X:  accel_x        <= cfg_data;
        CFG_ACCEL_Y:  accel_y        <= cfg_data;
        CFG_ACCEL_Z:  accel_z        <= cfg_data;
        CFG_DRAG:     drag_factor    <= cfg_data[15:0];
        CFG_GRAVITY:  gravity_on     <= cfg_data[0];
        CFG_REST_THR: rest_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      cur_z       <= '0;
      prev_x      <= '0;
      prev_y      <= '0;
      prev_z      <= '0;
      still_count <= '0;
      rest_flag   <= 1'b0;
    end else if (cmd.commit) begin
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      cur_z       <= cur_z_next;
      prev_x      <= prev_x_next;
      prev_y      <= prev_y_next;
      prev_z      <= prev_z_next;
      still_count <= still_count_next;
      rest_flag   <= rest_flag_next;
    end
  end

  // state only moves on commit, which waits for a free output slot
  assign m_tdata = {3'b000, still_count, rest_flag, cur_z, cur_y, cur_x};

endmodule

[hw/rtl/vpi_ctrl.sv]
// Controller: sequences one transaction through the lanes and owns output valid.
module vpi_ctrl
  import vpi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_MUL1   = 7'b0000010,
    ST_MUL2   = 7'b0000100,
    ST_MUL3   = 7'b0001000,
    ST_SUM    = 7'b0010000,
    ST_SQ     = 7'b0100000,
    ST_COMMIT = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   m_tvalid_next;
  logic   slot_free;

  assign s_tready   = (state == ST_IDLE);
  assign slot_free  = !m_tvalid || m_tready;
  assign cmd.load   = s_tvalid && s_tready;
  assign cmd.commit = (state == ST_COMMIT) && slot_free;

  always_comb begin
    state_next    = state;
    m_tvalid_next = m_tvalid && !m_tready;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = status.tick_run ? ST_MUL1 : ST_COMMIT;
        end
      end
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_MUL3;
      ST_MUL3: state_next = ST_SUM;
      ST_SUM:  state_next = ST_SQ;
      ST_SQ:   state_next = ST_COMMIT;
      ST_COMMIT: begin
        if (slot_free) begin
          m_tvalid_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

[hw/rtl/verlet_point_integrator_unit.sv]
// Top level of the Verlet point integrator.
// One point body integrated by position Verlet in Q16.16, with rest detection.
// Commands arrive on s_tuser (tick, displace, set rest flag); every transaction
// returns one result holding the position, rest flag and still-tick count
// after the command. A tick on a moving body runs through the chain of three
// registered multiplies per axis, the saturating add, the squared-move stage
// and the commit; displace, set rest flag, a tick at rest and the unused code
// go straight to the commit, and one transaction is handled at a time. The next
// transaction is accepted as soon as the previous result has been loaded into
// the output, even while that result still waits to be taken. Configuration
// writes are taken every cycle and must only be issued while the block is idle.
module verlet_point_integrator_unit
  import vpi_pkg::*;
#(
  parameter int REST_FRAMES = REST_FRAMES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // dt[15:0], dx[47:16], dy[79:48], dz[111:80], rest_value[112], zero fill
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // cmd[1:0]
  input  logic [1:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], at_rest[96], still_frames[100:97]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]            cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  vpi_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .status(status), .cmd(cmd)
  );

  vpi_datapath #(.REST_FRAMES(REST_FRAMES)) u_dp (
    .clk(clk), .rst(rst), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .cfg_wr(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .status(status), .m_tdata(m_tdata)
  );

endmodule

[hw/rtl/vpi_checker.sv]
// Port-level checker of the integrator and its bind to the top level.
module vpi_checker
  import vpi_pkg::*;
#(
  parameter int REST_FRAMES = REST_FRAMES_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction taken while busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(m_tdata[100:97]) < REST_FRAMES))
    else $error("still count out of range");

  a_rest_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[96] |-> m_tdata[100:97] == 4'd0)
    else $error("still count not cleared at rest");

endmodule

bind verlet_point_integrator_unit vpi_checker #(.REST_FRAMES(REST_FRAMES)) u_vpi_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
